/* hdl/mps_pkg.sv */
// mps_pkg: word format, payload structs, register indexes and the saturating
// fixed-point helpers used by the predictor stencil pipeline.
// No dependencies.
package mps_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int UREG_BITS    = 31;
  localparam int WEIGHT_BITS  = 17;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_INV_RE  = 3'd0,
    REG_FORCE_X = 3'd1,
    REG_FORCE_Y = 3'd2,
    REG_UPWIND  = 3'd3,
    REG_DT      = 3'd4,
    REG_INV_W   = 3'd5,
    REG_INV_H   = 3'd6
  } cfg_reg_e;

  localparam logic [UREG_BITS-1:0]   RST_INV_RE = UREG_BITS'(65536);
  localparam logic [UREG_BITS-1:0]   RST_DT     = UREG_BITS'(6554);
  localparam logic [UREG_BITS-1:0]   RST_INV_SZ = UREG_BITS'(65536);
  localparam logic [WEIGHT_BITS-1:0] RST_UPWIND = '0;

  typedef struct packed {
    logic  cmd;
    logic  boundary_cell;
    word_t own_center;
    word_t own_next_along;
    word_t own_prev_along;
    word_t own_next_across;
    word_t own_prev_across;
    word_t cross_here_first;
    word_t cross_here_second;
    word_t cross_back_first;
    word_t cross_back_second;
  } in_t;

  typedef struct packed {
    word_t predictor_value;
    logic  saturated;
  } out_t;

  typedef struct packed {
    logic  clamp;
    word_t val;
  } sval_t;

  localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [2*WORD_BITS-1:0] LIM_POS = {{(WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic [2*WORD_BITS-1:0] LIM_NEG = {{WORD_BITS{1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}};

  function automatic sval_t sat_wide(logic [WORD_BITS:0] v);
    sval_t r;
    if (v[WORD_BITS] != v[WORD_BITS-1]) begin
      r.clamp = 1'b1;
      r.val   = v[WORD_BITS] ? WMIN : WMAX;
    end else begin
      r.clamp = 1'b0;
      r.val   = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic sval_t s_add(word_t a, word_t b);
    return sat_wide({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
  endfunction

  function automatic sval_t s_sub(word_t a, word_t b);
    return sat_wide({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b});
  endfunction

  function automatic sval_t s_abs(word_t a);
    sval_t r;
    if (!a[WORD_BITS-1]) begin
      r.clamp = 1'b0;
      r.val   = a;
    end else begin
      r = s_sub('0, a);
    end
    return r;
  endfunction

  // floor((a+b)/2), exact
  function automatic word_t half_sum(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    return s[WORD_BITS:1];
  endfunction

  // floor((a-b)/2), exact
  function automatic word_t half_diff(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    return s[WORD_BITS:1];
  endfunction

  // full product, magnitude truncated toward zero, then saturated
  function automatic sval_t s_mul(word_t a, word_t b);
    logic [2*WORD_BITS-1:0] p;
    logic [2*WORD_BITS-1:0] mag;
    logic [2*WORD_BITS-1:0] q;
    logic                   neg;
    sval_t                  r;
    p   = {{WORD_BITS{a[WORD_BITS-1]}}, a} * {{WORD_BITS{b[WORD_BITS-1]}}, b};
    neg = p[2*WORD_BITS-1];
    mag = neg ? (~p + 1'b1) : p;
    q   = mag >> FRAC_BITS;
    r.clamp = 1'b0;
    if (!neg && q > LIM_POS) begin
      r.clamp = 1'b1;
      r.val   = WMAX;
    end else if (neg && q > LIM_NEG) begin
      r.clamp = 1'b1;
      r.val   = WMIN;
    end else begin
      r.val = neg ? (~q[WORD_BITS-1:0] + 1'b1) : q[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/momentum_predictor_stencil.sv */
// momentum_predictor_stencil: top level, eight-stage predictor pipeline and
// the configuration registers. Depends on mps_pkg.
//
// Computes one F (cmd 0) or G (cmd 1) predictor per cell from a 5-point own
// stencil and four cross values, all signed Q16.16 with saturation; any clamp
// sets the saturated flag, boundary cells pass own_center with the flag clear.
// One cell is taken every clock while the output is not stalled; the pipeline
// depth is set by the serial chain of three multiplies in the diffusion path
// plus the final dt product, each in its own stage. A stalled output freezes the whole
// pipeline. Registers are written through the config channel, always ready,
// and must only change while no cell is in flight.
module momentum_predictor_stencil (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  mps_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mps_pkg::out_t                     out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mps_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [mps_pkg::WORD_BITS-1:0]     cfg_data_i
);
  import mps_pkg::*;

  localparam int NS = 8;

  // configuration registers
  logic [UREG_BITS-1:0]   inv_re_q, dt_q, inv_w_q, inv_h_q;
  logic [WORD_BITS-1:0]   force_x_q, force_y_q;
  logic [WEIGHT_BITS-1:0] upwind_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_re_q  <= RST_INV_RE;
      force_x_q <= '0;
      force_y_q <= '0;
      upwind_q  <= RST_UPWIND;
      dt_q      <= RST_DT;
      inv_w_q   <= RST_INV_SZ;
      inv_h_q   <= RST_INV_SZ;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_INV_RE:  inv_re_q  <= cfg_data_i[UREG_BITS-1:0];
        REG_FORCE_X: force_x_q <= cfg_data_i;
        REG_FORCE_Y: force_y_q <= cfg_data_i;
        REG_UPWIND:  upwind_q  <= cfg_data_i[WEIGHT_BITS-1:0];
        REG_DT:      dt_q      <= cfg_data_i[UREG_BITS-1:0];
        REG_INV_W:   inv_w_q   <= cfg_data_i[UREG_BITS-1:0];
        REG_INV_H:   inv_h_q   <= cfg_data_i[UREG_BITS-1:0];
        default: ;
      endcase
    end
  end

  word_t inv_re_w, dt_w, inv_w_w, inv_h_w, alpha_w;
  assign inv_re_w = WORD_BITS'(inv_re_q);
  assign dt_w     = WORD_BITS'(dt_q);
  assign inv_w_w  = WORD_BITS'(inv_w_q);
  assign inv_h_w  = WORD_BITS'(inv_h_q);
  assign alpha_w  = WORD_BITS'(upwind_q);

  function automatic word_t inv_along(logic cmd, word_t iw, word_t ih);
    return cmd ? ih : iw;
  endfunction

  typedef struct packed {
    logic cmd; logic bnd; logic cl; word_t c;
    word_t da, dc, oa, ob, oc, od, va, vb;
    word_t aoa, aob, ava, avb, ha1, ha2, hc1, hc2, coefa, coefc;
  } s1_t;
  typedef struct packed {
    logic cmd; logic bnd; logic cl; word_t c;
    word_t ma1, mc1, pa1, pa2, pc1, pc2, qa1, qa2, qc1, qc2, coefa, coefc;
  } s2_t;
  typedef struct packed {
    logic cmd; logic bnd; logic cl; word_t c;
    word_t ma2, mc2, cena, cenc, dona, donc, coefa, coefc;
  } s3_t;
  typedef struct packed {
    logic cmd; logic bnd; logic cl; word_t c;
    word_t dsum, ca, cc, dna, dnc;
  } s4_t;
  typedef struct packed {
    logic cmd; logic bnd; logic cl; word_t c;
    word_t tdf, conva, convc;
  } s5_t;
  typedef struct packed {
    logic bnd; logic cl; word_t c; word_t t;
  } s6_t;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  s6_t s6_d, s6_q, s7_d, s7_q;
  out_t out_d, out_q;
  logic [NS-1:0] v_q;
  logic en;

  // whole pipe advances unless the output holds an untaken result
  assign en          = !v_q[NS-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = out_q;

  // stage 1: sums, half sums, absolute values, upwind coefficients
  always_comb begin
    sval_t ap, cc2, da, pc2, dc, aoa, aob, ava, avb, cfa, cfc;
    word_t ial, iac;
    ial = inv_along(in_data_i.cmd, inv_w_w, inv_h_w);
    iac = inv_along(!in_data_i.cmd, inv_w_w, inv_h_w);
    s1_d.cmd = in_data_i.cmd;
    s1_d.bnd = in_data_i.boundary_cell;
    s1_d.c   = in_data_i.own_center;
    ap  = s_add(in_data_i.own_next_along, in_data_i.own_prev_along);
    cc2 = s_add(in_data_i.own_center, in_data_i.own_center);
    da  = s_sub(ap.val, cc2.val);
    pc2 = s_add(in_data_i.own_next_across, in_data_i.own_prev_across);
    dc  = s_sub(pc2.val, cc2.val);
    s1_d.da = da.val;
    s1_d.dc = dc.val;
    s1_d.oa = half_sum(in_data_i.own_center, in_data_i.own_next_along);
    s1_d.ob = half_sum(in_data_i.own_prev_along, in_data_i.own_center);
    s1_d.oc = half_sum(in_data_i.own_center, in_data_i.own_next_across);
    s1_d.od = half_sum(in_data_i.own_prev_across, in_data_i.own_center);
    s1_d.va = half_sum(in_data_i.cross_here_first, in_data_i.cross_here_second);
    s1_d.vb = half_sum(in_data_i.cross_back_first, in_data_i.cross_back_second);
    aoa = s_abs(s1_d.oa);
    aob = s_abs(s1_d.ob);
    ava = s_abs(s1_d.va);
    avb = s_abs(s1_d.vb);
    s1_d.aoa = aoa.val;
    s1_d.aob = aob.val;
    s1_d.ava = ava.val;
    s1_d.avb = avb.val;
    s1_d.ha1 = half_diff(in_data_i.own_center, in_data_i.own_next_along);
    s1_d.ha2 = half_diff(in_data_i.own_prev_along, in_data_i.own_center);
    s1_d.hc1 = half_diff(in_data_i.own_center, in_data_i.own_next_across);
    s1_d.hc2 = half_diff(in_data_i.own_prev_across, in_data_i.own_center);
    cfa = s_mul(alpha_w, ial);
    cfc = s_mul(alpha_w, iac);
    s1_d.coefa = cfa.val;
    s1_d.coefc = cfc.val;
    s1_d.cl = ap.clamp | cc2.clamp | da.clamp | pc2.clamp | dc.clamp | aoa.clamp
            | aob.clamp | ava.clamp | avb.clamp | cfa.clamp | cfc.clamp;
  end

  // stage 2: first diffusion scale, central and donor products
  always_comb begin
    sval_t ma1, mc1, pa1, pa2, pc1, pc2, qa1, qa2, qc1, qc2;
    ma1 = s_mul(s1_q.da, inv_along(s1_q.cmd, inv_w_w, inv_h_w));
    mc1 = s_mul(s1_q.dc, inv_along(!s1_q.cmd, inv_w_w, inv_h_w));
    pa1 = s_mul(s1_q.oa, s1_q.oa);
    pa2 = s_mul(s1_q.ob, s1_q.ob);
    pc1 = s_mul(s1_q.va, s1_q.oc);
    pc2 = s_mul(s1_q.vb, s1_q.od);
    qa1 = s_mul(s1_q.aoa, s1_q.ha1);
    qa2 = s_mul(s1_q.aob, s1_q.ha2);
    qc1 = s_mul(s1_q.ava, s1_q.hc1);
    qc2 = s_mul(s1_q.avb, s1_q.hc2);
    s2_d.cmd = s1_q.cmd;
    s2_d.bnd = s1_q.bnd;
    s2_d.c   = s1_q.c;
    s2_d.ma1 = ma1.val;
    s2_d.mc1 = mc1.val;
    s2_d.pa1 = pa1.val;
    s2_d.pa2 = pa2.val;
    s2_d.pc1 = pc1.val;
    s2_d.pc2 = pc2.val;
    s2_d.qa1 = qa1.val;
    s2_d.qa2 = qa2.val;
    s2_d.qc1 = qc1.val;
    s2_d.qc2 = qc2.val;
    s2_d.coefa = s1_q.coefa;
    s2_d.coefc = s1_q.coefc;
    s2_d.cl = s1_q.cl | ma1.clamp | mc1.clamp | pa1.clamp | pa2.clamp | pc1.clamp
            | pc2.clamp | qa1.clamp | qa2.clamp | qc1.clamp | qc2.clamp;
  end

  // stage 3: second diffusion scale, product differences
  always_comb begin
    sval_t ma2, mc2, cena, cenc, dona, donc;
    ma2  = s_mul(s2_q.ma1, inv_along(s2_q.cmd, inv_w_w, inv_h_w));
    mc2  = s_mul(s2_q.mc1, inv_along(!s2_q.cmd, inv_w_w, inv_h_w));
    cena = s_sub(s2_q.pa1, s2_q.pa2);
    cenc = s_sub(s2_q.pc1, s2_q.pc2);
    dona = s_sub(s2_q.qa1, s2_q.qa2);
    donc = s_sub(s2_q.qc1, s2_q.qc2);
    s3_d.cmd   = s2_q.cmd;
    s3_d.bnd   = s2_q.bnd;
    s3_d.c     = s2_q.c;
    s3_d.ma2   = ma2.val;
    s3_d.mc2   = mc2.val;
    s3_d.cena  = cena.val;
    s3_d.cenc  = cenc.val;
    s3_d.dona  = dona.val;
    s3_d.donc  = donc.val;
    s3_d.coefa = s2_q.coefa;
    s3_d.coefc = s2_q.coefc;
    s3_d.cl = s2_q.cl | ma2.clamp | mc2.clamp | cena.clamp | cenc.clamp
            | dona.clamp | donc.clamp;
  end

  // stage 4: diffusion sum, scaled central and donor terms
  always_comb begin
    sval_t dsum, ca, cc, dna, dnc;
    dsum = s_add(s3_q.ma2, s3_q.mc2);
    ca   = s_mul(inv_along(s3_q.cmd, inv_w_w, inv_h_w), s3_q.cena);
    cc   = s_mul(inv_along(!s3_q.cmd, inv_w_w, inv_h_w), s3_q.cenc);
    dna  = s_mul(s3_q.coefa, s3_q.dona);
    dnc  = s_mul(s3_q.coefc, s3_q.donc);
    s4_d.cmd  = s3_q.cmd;
    s4_d.bnd  = s3_q.bnd;
    s4_d.c    = s3_q.c;
    s4_d.dsum = dsum.val;
    s4_d.ca   = ca.val;
    s4_d.cc   = cc.val;
    s4_d.dna  = dna.val;
    s4_d.dnc  = dnc.val;
    s4_d.cl = s3_q.cl | dsum.clamp | ca.clamp | cc.clamp | dna.clamp | dnc.clamp;
  end

  // stage 5: viscous term, convection totals
  always_comb begin
    sval_t tdf, conva, convc;
    tdf   = s_mul(inv_re_w, s4_q.dsum);
    conva = s_add(s4_q.ca, s4_q.dna);
    convc = s_add(s4_q.cc, s4_q.dnc);
    s5_d.cmd   = s4_q.cmd;
    s5_d.bnd   = s4_q.bnd;
    s5_d.c     = s4_q.c;
    s5_d.tdf   = tdf.val;
    s5_d.conva = conva.val;
    s5_d.convc = convc.val;
    s5_d.cl = s4_q.cl | tdf.clamp | conva.clamp | convc.clamp;
  end

  // stage 6: right-hand side in model order, then body force
  always_comb begin
    sval_t t1, t2, t3;
    t1 = s_sub(s5_q.tdf, s5_q.conva);
    t2 = s_sub(t1.val, s5_q.convc);
    t3 = s_add(t2.val, s5_q.cmd ? word_t'(force_y_q) : word_t'(force_x_q));
    s6_d.bnd = s5_q.bnd;
    s6_d.c   = s5_q.c;
    s6_d.t   = t3.val;
    s6_d.cl  = s5_q.cl | t1.clamp | t2.clamp | t3.clamp;
  end

  // stage 7: dt product
  always_comb begin
    sval_t pr;
    pr = s_mul(dt_w, s6_q.t);
    s7_d.bnd = s6_q.bnd;
    s7_d.c   = s6_q.c;
    s7_d.t   = pr.val;
    s7_d.cl  = s6_q.cl | pr.clamp;
  end

  // stage 8: add center, boundary bypass
  always_comb begin
    sval_t r;
    r = s_add(s7_q.c, s7_q.t);
    if (s7_q.bnd) begin
      out_d.predictor_value = s7_q.c;
      out_d.saturated       = 1'b0;
    end else begin
      out_d.predictor_value = r.val;
      out_d.saturated       = s7_q.cl | r.clamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      s4_q  <= s4_d;
      s5_q  <= s5_d;
      s6_q  <= s6_d;
      s7_q  <= s7_d;
      out_q <= out_d;
    end
  end

  // a stalled pipe keeps every slot occupancy
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline occupancy changed during stall");

  // an accepted cell lands in the first stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted cell missing from first stage");

  // no transfer in while a result waits untaken
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while output stalled");

endmodule

/* dv/testbench.sv */
// testbench: self-checking bench for the F/G predictor stencil pipeline.
// Depends on mps_pkg and momentum_predictor_stencil; a scoreboard class
// predicts each cell in fixed point and checks results in order.
module testbench;
  import mps_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_CYCLES    = 300;

  class predictor_board;
    out_t        pending[$];
    logic [31:0] regs[7];
    bit          clamped;
    int          errors;
    int          checked;
    int          sat_seen;

    function new();
      regs[REG_INV_RE]  = 32'(RST_INV_RE);
      regs[REG_FORCE_X] = '0;
      regs[REG_FORCE_Y] = '0;
      regs[REG_UPWIND]  = 32'(RST_UPWIND);
      regs[REG_DT]      = 32'(RST_DT);
      regs[REG_INV_W]   = 32'(RST_INV_SZ);
      regs[REG_INV_H]   = 32'(RST_INV_SZ);
    endfunction

    function void set_reg(cfg_reg_e idx, logic [31:0] d);
      case (idx)
        REG_INV_RE, REG_DT, REG_INV_W, REG_INV_H: regs[idx] = {1'b0, d[30:0]};
        REG_UPWIND: regs[idx] = {15'd0, d[16:0]};
        REG_FORCE_X, REG_FORCE_Y: regs[idx] = d;
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      if (v > longint'(WMAX)) begin
        clamped = 1; return longint'(WMAX);
      end
      if (v < longint'(WMIN)) begin
        clamped = 1; return longint'(WMIN);
      end
      return v;
    endfunction

    function longint fx_abs(longint a);
      return (a >= 0) ? a : clip(-a);
    endfunction

    // truncate magnitude toward zero, then clamp
    function longint fx_mul(longint a, longint b);
      longint p, q;
      p = a * b;
      q = ((p < 0) ? -p : p) >>> FRAC_BITS;
      if (p < 0) begin
        if (q > 64'sd2147483648) begin
          clamped = 1; return longint'(WMIN);
        end
        return -q;
      end
      if (q > longint'(WMAX)) begin
        clamped = 1; return longint'(WMAX);
      end
      return q;
    endfunction

    function longint second_diff(longint nx, longint c, longint pv, longint inv);
      longint d;
      d = clip(clip(nx + pv) - clip(c + c));
      return fx_mul(fx_mul(d, inv), inv);
    endfunction

    function longint transport(longint fa, longint ga, longint fb, longint gb,
                               longint dfa, longint dfb, longint inv, longint alpha);
      longint central, donor;
      central = fx_mul(inv, clip(fx_mul(fa, ga) - fx_mul(fb, gb)));
      donor = clip(fx_mul(fx_abs(fa), dfa) - fx_mul(fx_abs(fb), dfb));
      return clip(central + fx_mul(fx_mul(alpha, inv), donor));
    endfunction

    function void note_cell(in_t x);
      out_t   r;
      longint c, na, pa, nc, pc, hf, hs, bf, bs;
      longint inv_re, force_v, alpha, dt, inv_al, inv_ac, t, oa, ob, oc, od, va, vb;
      clamped = 0;
      if (x.boundary_cell) begin
        r.predictor_value = x.own_center;
        r.saturated = 1'b0;
      end else begin
        c  = x.own_center;       na = x.own_next_along;  pa = x.own_prev_along;
        nc = x.own_next_across;  pc = x.own_prev_across;
        hf = x.cross_here_first; hs = x.cross_here_second;
        bf = x.cross_back_first; bs = x.cross_back_second;
        inv_re  = longint'(regs[REG_INV_RE]);
        force_v = x.cmd ? longint'(signed'(regs[REG_FORCE_Y]))
                        : longint'(signed'(regs[REG_FORCE_X]));
        alpha   = longint'(regs[REG_UPWIND]);
        dt      = longint'(regs[REG_DT]);
        inv_al  = x.cmd ? longint'(regs[REG_INV_H]) : longint'(regs[REG_INV_W]);
        inv_ac  = x.cmd ? longint'(regs[REG_INV_W]) : longint'(regs[REG_INV_H]);
        t = fx_mul(inv_re, clip(second_diff(na, c, pa, inv_al) +
                                second_diff(nc, c, pc, inv_ac)));
        oa = (c + na) >>> 1;
        ob = (pa + c) >>> 1;
        t = clip(t - transport(oa, oa, ob, ob, (c - na) >>> 1, (pa - c) >>> 1,
                               inv_al, alpha));
        va = (hf + hs) >>> 1;
        vb = (bf + bs) >>> 1;
        oc = (c + nc) >>> 1;
        od = (pc + c) >>> 1;
        t = clip(t - transport(va, oc, vb, od, (c - nc) >>> 1, (pc - c) >>> 1,
                               inv_ac, alpha));
        t = clip(t + force_v);
        t = clip(c + fx_mul(dt, t));
        r.predictor_value = t[31:0];
        r.saturated = clamped;
      end
      pending.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $error("result with nothing pending: value %h", got.predictor_value);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.saturated) sat_seen++;
      if (got.predictor_value !== want.predictor_value) begin
        $error("predictor_value: expected %h, actual %h",
               want.predictor_value, got.predictor_value);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %b, actual %b", want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  predictor_board board = new();
  in_t         cells[$];
  logic [31:0] reg_plan[7];
  bit          stall_out = 1'b1;
  bit          stall_in = 1'b1;
  bit          hold_req = 1'b0;
  int          quiet = 0;
  int          sent = 0;

  always #2 clk = ~clk;

  momentum_predictor_stencil u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold when requested
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = stall_out ? $urandom_range(0, 16) : 0;
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      board.check_result(out_data);
    end
  end

  task automatic write_plan();
    for (int k = 0; k < 7; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(k);
      cfg_data  <= reg_plan[k];
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
      board.set_reg(cfg_reg_e'(k), reg_plan[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_cells();
    int n;
    while (cells.size() > 0) begin
      n = stall_in ? $urandom_range(0, 16) : 0;
      if (n > 0) begin
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
      end
      in_data  <= cells[0];
      in_valid <= 1'b1;
      do @(posedge clk); while (!(in_valid && in_ready));
      board.note_cell(cells.pop_front());
      sent++;
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic word_t pick_word(int mode);
    case ($urandom_range(0, 9))
      0: return WMAX;
      1: return WMIN;
      2: return word_t'($urandom_range(0, 4) - 2);
      3: return word_t'($urandom());
      default: return (mode == 0) ? word_t'($urandom())
                                  : word_t'(int'($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  function automatic in_t rand_cell();
    in_t x;
    int  mode;
    mode = ($urandom_range(0, 4) == 0) ? 0 : 1;
    x.cmd = 1'($urandom_range(0, 1));
    x.boundary_cell = ($urandom_range(0, 7) == 0);
    x.own_center        = pick_word(mode);
    x.own_next_along    = pick_word(mode);
    x.own_prev_along    = pick_word(mode);
    x.own_next_across   = pick_word(mode);
    x.own_prev_across   = pick_word(mode);
    x.cross_here_first  = pick_word(mode);
    x.cross_here_second = pick_word(mode);
    x.cross_back_first  = pick_word(mode);
    x.cross_back_second = pick_word(mode);
    return x;
  endfunction

  function automatic in_t flat_cell(logic cmd, logic bnd, word_t c, word_t rest);
    in_t x;
    x = {cmd, bnd, c, rest, rest, rest, rest, rest, rest, rest, rest};
    return x;
  endfunction

  task automatic add_random(int n);
    repeat (n) cells.push_back(rand_cell());
  endtask

  initial begin
    in_t x;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed cells under reset settings
    for (int k = 0; k < 2; k++) begin
      cells.push_back(flat_cell(1'(k), 1'b1, WMIN, WMAX));
      cells.push_back(flat_cell(1'(k), 1'b0, '0, '0));
      cells.push_back(flat_cell(1'(k), 1'b0, WMAX, WMAX));
      cells.push_back(flat_cell(1'(k), 1'b0, WMIN, WMIN));
      cells.push_back(flat_cell(1'(k), 1'b0, WMIN, WMAX));
      cells.push_back(flat_cell(1'(k), 1'b0, word_t'(-1), word_t'(1)));
      cells.push_back(flat_cell(1'(k), 1'b0, word_t'(65536), word_t'(-3)));
    end
    // odd neighbors exercise floor rounding of half sums and differences
    x = flat_cell(1'b0, 1'b0, word_t'(3), word_t'(-5));
    x.own_prev_across = word_t'(-1);
    x.cross_back_second = WMIN;
    cells.push_back(x);
    x = flat_cell(1'b1, 1'b0, word_t'(131072), word_t'(-65536));
    x.own_next_along = word_t'(196608);
    cells.push_back(x);
    send_cells();
    add_random(190);
    send_cells();
    drain();

    // every register at its top value but force Y at its most negative, weight above one
    reg_plan = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    write_plan();
    add_random(150);
    send_cells();
    drain();

    // everything zero
    reg_plan = '{32'h8000_0000, 32'h0, 32'h0, 32'hFFFE_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    write_plan();
    add_random(150);
    send_cells();
    drain();

    // moderate flow settings; output held off while input keeps coming
    reg_plan = '{32'd655, 32'hFFFF_8000, 32'd16384, 32'd65536,
                 32'd3277, 32'd262144, 32'd131072};
    write_plan();
    stall_in = 1'b0;
    hold_req = 1'b1;
    add_random(150);
    send_cells();
    stall_in = 1'b1;
    stall_out = 1'b0;
    add_random(100);
    send_cells();
    stall_out = 1'b1;
    add_random(150);
    send_cells();
    drain();

    for (int p = 0; p < 4; p++) begin
      foreach (reg_plan[k]) reg_plan[k] = $urandom();
      if (p[0]) reg_plan[REG_UPWIND] = $urandom_range(0, 65536);
      write_plan();
      add_random(237);
      send_cells();
      drain();
    end

    $display("covered %0d cells over 8 register settings, %0d results checked",
             sent, board.checked);
    $display("%0d results flagged as saturated, %0d mismatches",
             board.sat_seen, board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
